FILE: design/ttr_pkg.sv
package ttr_pkg;

  // Conversion from milliseconds to local time units.
  localparam int unsigned UNITS_PER_MS = 1000;

  localparam int unsigned TICK_W   = 32;
  localparam int unsigned IVL_IN_W = 16;
  localparam int unsigned IVL_W    = 15;
  localparam int unsigned TIME_W   = 63;
  localparam int unsigned THR_W    = 32;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned WIDE_W   = 64;

  localparam int unsigned UNITS_W = $clog2(UNITS_PER_MS + 1);
  localparam int unsigned SCALE_W = IVL_W + UNITS_W;
  localparam int unsigned MUL_W   = SCALE_W + TICK_W;

  localparam logic [IVL_W-1:0] DEFAULT_IVL_RST = IVL_W'(50);
  localparam logic [THR_W-1:0] DRIFT_THR_RST   = THR_W'(5000);
  localparam logic [CNT_W-1:0] CONFIRM_RST     = CNT_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEFAULT_IVL = 2'd0,
    CFG_DRIFT_THR   = 2'd1,
    CFG_CONFIRM     = 2'd2
  } cfg_idx_t;

  // Anchor state carried from one item to the next.
  typedef struct packed {
    logic              init;
    logic [IVL_W-1:0]  ivl;
    logic [TIME_W-1:0] anchor_time;
    logic [TICK_W-1:0] anchor_tick;
    logic [CNT_W-1:0]  late_cnt;
  } anchor_t;

  // Item as held in the input register.
  typedef struct packed {
    logic [TICK_W-1:0]  tick;
    logic [IVL_W-1:0]   ivl;
    logic [SCALE_W-1:0] scale;
    logic [TIME_W-1:0]  arrival;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0] sample_time;
    logic              anchored;
  } result_t;

  // A positive interval is used as given; zero or negative selects the default.
  function automatic logic [IVL_W-1:0] pick_interval(input logic [IVL_IN_W-1:0] raw,
                                                     input logic [IVL_W-1:0] dflt);
    logic [IVL_W-1:0] v;
    v = raw[IVL_W-1:0];
    if (!raw[IVL_IN_W-1] && (v != '0)) begin
      return v;
    end
    return dflt;
  endfunction

endpackage

FILE: design/ttr_if.sv
interface ttr_in_if;
  logic                                valid;
  logic                                ready;
  logic [ttr_pkg::TICK_W-1:0]          sender_tick;
  logic signed [ttr_pkg::IVL_IN_W-1:0] interval_ms;
  logic [ttr_pkg::TIME_W-1:0]          arrival_time;

  modport source (output valid, sender_tick, interval_ms, arrival_time, input ready);
  modport sink (input valid, sender_tick, interval_ms, arrival_time, output ready);
endinterface

interface ttr_out_if;
  logic                       valid;
  logic                       ready;
  logic [ttr_pkg::TIME_W-1:0] sample_time;
  logic                       anchored;

  modport source (output valid, sample_time, anchored, input ready);
  modport sink (input valid, sample_time, anchored, output ready);
endinterface

FILE: design/ttr_resolve.sv
// Resolves one item against the current anchor and produces the next anchor.
module ttr_resolve (
  input  ttr_pkg::anchor_t              st,
  input  ttr_pkg::item_t                item,
  input  logic [ttr_pkg::THR_W-1:0]     drift_thr,
  input  logic [ttr_pkg::CNT_W-1:0]     confirm,
  output ttr_pkg::result_t              res,
  output ttr_pkg::anchor_t              st_nxt
);

  logic [ttr_pkg::TICK_W-1:0] offset;
  logic [ttr_pkg::MUL_W-1:0]  span;
  logic [ttr_pkg::WIDE_W-1:0] predicted;
  logic [ttr_pkg::WIDE_W:0]   diff;
  logic                       late;
  logic [ttr_pkg::CNT_W-1:0]  cnt_inc;
  logic                       reanchor;

  assign offset    = item.tick - st.anchor_tick;
  assign span      = ttr_pkg::MUL_W'(item.scale) * ttr_pkg::MUL_W'(offset);
  assign predicted = ttr_pkg::WIDE_W'(st.anchor_time) + ttr_pkg::WIDE_W'(span);
  // The top bit of diff is the borrow: set when arrival is below the prediction.
  assign diff      = (ttr_pkg::WIDE_W + 1)'(item.arrival) - {1'b0, predicted};
  assign late      = !diff[ttr_pkg::WIDE_W] && (diff[ttr_pkg::WIDE_W-1:0] != '0) &&
                     (diff[ttr_pkg::WIDE_W-1:0] >= ttr_pkg::WIDE_W'(drift_thr));
  assign cnt_inc   = st.late_cnt + ttr_pkg::CNT_W'(1);

  always_comb begin
    st_nxt   = st;
    reanchor = 1'b0;
    priority if (!st.init || (item.ivl != st.ivl)) begin
      reanchor = 1'b1;
    end else if (late) begin
      st_nxt.late_cnt = cnt_inc;
      reanchor        = (cnt_inc >= confirm);
    end else begin
      st_nxt.late_cnt = '0;
    end
    if (reanchor) begin
      st_nxt.init        = 1'b1;
      st_nxt.ivl         = item.ivl;
      st_nxt.anchor_time = item.arrival;
      st_nxt.anchor_tick = item.tick;
      st_nxt.late_cnt    = '0;
    end
    res.anchored    = reanchor;
    res.sample_time = reanchor ? item.arrival : predicted[ttr_pkg::TIME_W-1:0];
  end

endmodule

FILE: design/tick_timestamp_reanchor_core.sv
// Channel  | Dir | Payload                                            | Handshake
// in_chan  | in  | sender_tick[31:0], interval_ms[15:0] s, arrival[62:0] | valid/ready
// out_chan | out | sample_time[62:0], anchored                        | valid/ready
// cfg_*    | in  | cfg_index[1:0], cfg_wdata[31:0]                    | cfg_we only
//
// An accepted input beat passes the input register and then the result register.
// One beat is taken per cycle while the output is not stalled. The rate is set by
// the anchor loop: the offset subtract, one 25x32 multiply, a 64-bit add and the
// lateness compare all resolve combinationally between the input and result registers.
// Reset (synchronous, rst_n low) clears the anchor and loads register defaults.
// A stalled output freezes both stages; the input register still fills if empty.

module tick_timestamp_reanchor_core (
  input  logic                            clk,
  input  logic                            rst_n,
  ttr_in_if.sink                          in_chan,
  ttr_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [ttr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ttr_pkg::CFG_W-1:0]       cfg_wdata
);

  // Configuration registers.
  logic [ttr_pkg::IVL_W-1:0] default_ivl_r;
  logic [ttr_pkg::THR_W-1:0] drift_thr_r;
  logic [ttr_pkg::CNT_W-1:0] confirm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_ivl_r <= ttr_pkg::DEFAULT_IVL_RST;
      drift_thr_r   <= ttr_pkg::DRIFT_THR_RST;
      confirm_r     <= ttr_pkg::CONFIRM_RST;
    end else if (cfg_we) begin
      unique case (ttr_pkg::cfg_idx_t'(cfg_index))
        ttr_pkg::CFG_DEFAULT_IVL: default_ivl_r <= cfg_wdata[ttr_pkg::IVL_W-1:0];
        ttr_pkg::CFG_DRIFT_THR:   drift_thr_r   <= cfg_wdata[ttr_pkg::THR_W-1:0];
        ttr_pkg::CFG_CONFIRM:     confirm_r     <= cfg_wdata[ttr_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control. Both stages move together whenever the result register
  // is free or being drained this cycle.
  logic            s1_valid_r;
  ttr_pkg::item_t  s1_item_r;
  ttr_pkg::item_t  s1_item_nxt;
  logic            out_valid_r;
  ttr_pkg::result_t out_res_r;
  logic            advance;
  logic            in_fire;
  logic            s1_fire;

  assign advance       = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !s1_valid_r || advance;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign s1_fire       = s1_valid_r && advance;

  // The interval is settled and scaled to time units on capture, so the
  // anchor loop carries only a single multiply.
  always_comb begin
    s1_item_nxt.tick    = in_chan.sender_tick;
    s1_item_nxt.ivl     = ttr_pkg::pick_interval(in_chan.interval_ms, default_ivl_r);
    s1_item_nxt.scale   = ttr_pkg::SCALE_W'(s1_item_nxt.ivl) *
                          ttr_pkg::SCALE_W'(ttr_pkg::UNITS_PER_MS);
    s1_item_nxt.arrival = in_chan.arrival_time;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= s1_item_nxt;
    end
  end

  // Anchor state and the resolve step.
  ttr_pkg::anchor_t  anchor_r;
  ttr_pkg::anchor_t  anchor_nxt;
  ttr_pkg::result_t  res_nxt;

  ttr_resolve u_resolve (
    .st        (anchor_r),
    .item      (s1_item_r),
    .drift_thr (drift_thr_r),
    .confirm   (confirm_r),
    .res       (res_nxt),
    .st_nxt    (anchor_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_r.init        <= 1'b0;
      anchor_r.ivl         <= ttr_pkg::DEFAULT_IVL_RST;
      anchor_r.anchor_time <= '0;
      anchor_r.anchor_tick <= '0;
      anchor_r.late_cnt    <= '0;
    end else if (s1_fire) begin
      anchor_r <= anchor_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.sample_time = out_res_r.sample_time;
  assign out_chan.anchored    = out_res_r.anchored;

  // The first item after reset always anchors.
  a_first_anchors: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !anchor_r.init |=> out_valid_r && out_res_r.anchored && anchor_r.init)
    else $error("first item after reset did not anchor");

  // Re-anchoring always clears the late count.
  a_anchor_clears_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && res_nxt.anchored |=> anchor_r.late_cnt == '0)
    else $error("late count not cleared on re-anchor");

  // A result can only exist once the anchor has been set.
  a_result_needs_anchor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> anchor_r.init)
    else $error("result present without an anchor");

  // The input register is never overwritten while its item is held.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && s1_valid_r && !advance))
    else $error("input register overwritten while stalled");

endmodule
